>>> design/assert_macros.svh
// assertion macros shared by the rtl modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every rising edge of clock while reset is low
`define BTMB_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);

// checked on every rising edge of clock, reset included
`define BTMB_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

>>> design/btmb_pkg.sv
// shared types and constants of the bilinear texel modulate blend unit
`timescale 1ns / 1ps
`default_nettype none

package btmb_pkg;

   // pipeline depth, one valid bit per register stage
   localparam int NSTAGE   = 6;
   localparam int CHANNELS = 4;

   // channel slots, matching the byte position in an argb word
   localparam int CH_BLUE  = 0;
   localparam int CH_GREEN = 1;
   localparam int CH_RED   = 2;
   localparam int CH_ALPHA = 3;

   // configuration register indexes
   localparam int CSR_INDEX_W = 4;
   localparam logic [CSR_INDEX_W-1:0] CSR_MOD_RED   = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] CSR_MOD_GREEN = CSR_INDEX_W'(1);
   localparam logic [CSR_INDEX_W-1:0] CSR_MOD_BLUE  = CSR_INDEX_W'(2);
   localparam logic [CSR_INDEX_W-1:0] CSR_MOD_ALPHA = CSR_INDEX_W'(3);

   // 255 * 255, the colour part of the common denominator
   localparam int BLEND_DIV = 65025;
   // scaled quotient at or above this saturates
   localparam int SAT_BOUND = 256 * BLEND_DIV;
   // width of the scaled quotient before and after the saturation check
   localparam int TRUNC_W   = 25;
   localparam int QIN_W     = 24;
   // ceil(2^40 / 65025), exact for dividends below 2^24
   localparam int RECIP_SHIFT = 40;
   localparam logic [TRUNC_W-1:0] RECIP_MUL = 25'd16909061;

   typedef struct packed {
      logic [NSTAGE-1:0] en;
      logic [NSTAGE-1:0] valid;
   } pipe_ctl_type;

   typedef struct packed {
      logic [7:0]                     mod_alpha;
      logic [CHANNELS-1:0][15:0]      factor;
   } blend_factor_type;

endpackage

`default_nettype wire

>>> design/bilinear_texel_modulate_blend_unit.sv
// top level of the bilinear texel modulate blend unit
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

// Shades one textured-quad pixel per transfer: the four neighbouring ARGB8888
// texels are filtered bilinearly with frac_x and frac_y (the low FRAC_BITS
// bits, units of 1/2^FRAC_BITS), multiplied by the modulation colour (RGB
// premultiplied by mod_alpha, 255 meaning 1.0) and composited over
// dest_pixel with a premultiplied-alpha over. Each channel is rounded once,
// to nearest with halves up, and saturated at 255. The pipeline takes one
// transfer every clock unless rsp_ready stalls it, and has six register stages;
// rsp_out_pixel comes from the last of them. In order they are:
// two stages of bilinear filtering in four channel lanes, then modulation,
// destination weighting, rounding and a reciprocal divide by 255*255, each
// in a register stage of its own. Every stage carries a valid bit and
// req_ready is worked out from the output end backwards, so empty stages
// keep filling while a result waits on rsp_ready; req_ready drops only when
// all six stages hold an item. The csr_ port takes a write every cycle;
// index 0..3 selects mod_red, mod_green, mod_blue, mod_alpha, others are
// dropped. All four reset to 255. Writes are meant for an idle pipeline.

module bilinear_texel_modulate_blend_unit import btmb_pkg::*; #(
   parameter int FRAC_BITS = 8
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   // configuration
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [7:0]             csr_wdata,
   // pixel request
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire logic [31:0]            req_texel_top_left,
   input  wire logic [31:0]            req_texel_top_right,
   input  wire logic [31:0]            req_texel_bottom_left,
   input  wire logic [31:0]            req_texel_bottom_right,
   input  wire logic [7:0]             req_frac_x,
   input  wire logic [7:0]             req_frac_y,
   input  wire logic [31:0]            req_dest_pixel,
   // blended pixel
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output logic [31:0]                 rsp_out_pixel
);

   localparam int BW = 2 * FRAC_BITS + 8;

   logic [NSTAGE-1:0]              valid_ff, valid_in, load;
   pipe_ctl_type                   ctl;
   blend_factor_type               factors;
   logic [FRAC_BITS+7:0]           fx_wide, fy_wide;
   logic [FRAC_BITS-1:0]           frac_x, frac_y;
   logic [CHANNELS-1:0][BW-1:0]    bilerp_value;
   logic [CHANNELS-1:0][7:0]       dest_s1_ff, dest_s2_ff, out_chan;

   btmb_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .factors   (factors)
   );

   // a stage loads when it is empty or its content moves on
   always_comb begin
      load[NSTAGE-1] = !valid_ff[NSTAGE-1] || rsp_ready;
      for (int k = NSTAGE - 2; k >= 0; k--) begin
         load[k] = !valid_ff[k] || load[k+1];
      end
      valid_in[0] = load[0] ? req_valid : valid_ff[0];
      for (int k = 1; k < NSTAGE; k++) begin
         valid_in[k] = load[k] ? valid_ff[k-1] : valid_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign ctl.en    = load;
   assign ctl.valid = valid_ff;
   assign req_ready = load[0];
   assign rsp_valid = valid_ff[NSTAGE-1];

   // only the low FRAC_BITS bits of each fraction weigh
   assign fx_wide = {{FRAC_BITS{1'b0}}, req_frac_x};
   assign fy_wide = {{FRAC_BITS{1'b0}}, req_frac_y};
   assign frac_x  = fx_wide[FRAC_BITS-1:0];
   assign frac_y  = fy_wide[FRAC_BITS-1:0];

   // one filter lane per channel
   for (genvar c = 0; c < CHANNELS; c++) begin : g_lane
      btmb_bilerp #(
         .FRAC_BITS (FRAC_BITS)
      ) u_bilerp (
         .clock        (clock),
         .texel_tl     (req_texel_top_left[8*c +: 8]),
         .texel_tr     (req_texel_top_right[8*c +: 8]),
         .texel_bl     (req_texel_bottom_left[8*c +: 8]),
         .texel_br     (req_texel_bottom_right[8*c +: 8]),
         .frac_x       (frac_x),
         .frac_y       (frac_y),
         .ctl          (ctl),
         .bilerp_value (bilerp_value[c])
      );
   end

   // destination pixel rides along with the filter stages
   always_ff @(posedge clock) begin
      if (load[0]) begin
         dest_s1_ff <= req_dest_pixel;
      end
      if (load[1]) begin
         dest_s2_ff <= dest_s1_ff;
      end
   end

   btmb_blend #(
      .FRAC_BITS (FRAC_BITS)
   ) u_blend (
      .clock        (clock),
      .reset        (reset),
      .bilerp_value (bilerp_value),
      .dest_chan    (dest_s2_ff),
      .factors      (factors),
      .ctl          (ctl),
      .out_chan     (out_chan)
   );

   assign rsp_out_pixel = out_chan;

   `BTMB_ASSERT(a_blocked_means_full, !req_ready |-> (&valid_ff), "input blocked with a free stage")
   `BTMB_ASSERT(a_transfer_enters, (req_valid && req_ready) |=> valid_ff[0], "accepted pixel lost")
   `BTMB_ASSERT_ALWAYS(a_reset_empties, reset |=> !rsp_valid, "result present after reset")

endmodule

`default_nettype wire

>>> design/btmb_csr.sv
// modulation colour registers and their premultiplied factors
`timescale 1ns / 1ps
`default_nettype none

module btmb_csr import btmb_pkg::*; (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [7:0]             csr_wdata,
   output blend_factor_type            factors
);

   logic [CHANNELS-1:0][7:0]  mod_ff, mod_in;
   logic [CHANNELS-1:0][15:0] factor_ff, factor_in;

   assign csr_ready = 1'b1;

   always_comb begin
      mod_in = mod_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_MOD_RED:   mod_in[CH_RED]   = csr_wdata;
            CSR_MOD_GREEN: mod_in[CH_GREEN] = csr_wdata;
            CSR_MOD_BLUE:  mod_in[CH_BLUE]  = csr_wdata;
            CSR_MOD_ALPHA: mod_in[CH_ALPHA] = csr_wdata;
            default:       mod_in = mod_ff;
         endcase
      end
   end

   // rgb premultiplied by alpha, alpha itself times 255
   always_comb begin
      factor_in[CH_BLUE]  = mod_ff[CH_BLUE]  * mod_ff[CH_ALPHA];
      factor_in[CH_GREEN] = mod_ff[CH_GREEN] * mod_ff[CH_ALPHA];
      factor_in[CH_RED]   = mod_ff[CH_RED]   * mod_ff[CH_ALPHA];
      factor_in[CH_ALPHA] = mod_ff[CH_ALPHA] * 8'hFF;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mod_ff    <= {CHANNELS{8'hFF}};
         factor_ff <= {CHANNELS{16'(BLEND_DIV)}};
      end else begin
         mod_ff    <= mod_in;
         factor_ff <= factor_in;
      end
   end

   assign factors.mod_alpha = mod_ff[CH_ALPHA];
   assign factors.factor    = factor_ff;

endmodule

`default_nettype wire

>>> design/btmb_bilerp.sv
// two-stage bilinear interpolation of one colour channel
`timescale 1ns / 1ps
`default_nettype none

module btmb_bilerp import btmb_pkg::*; #(
   parameter int FRAC_BITS = 8
) (
   input  wire logic                      clock,
   input  wire logic [7:0]                texel_tl,
   input  wire logic [7:0]                texel_tr,
   input  wire logic [7:0]                texel_bl,
   input  wire logic [7:0]                texel_br,
   input  wire logic [FRAC_BITS-1:0]      frac_x,
   input  wire logic [FRAC_BITS-1:0]      frac_y,
   input  wire pipe_ctl_type              ctl,
   output logic [2*FRAC_BITS+7:0]         bilerp_value
);

   localparam int ONE = 1 << FRAC_BITS;
   localparam int WW  = FRAC_BITS + 1;
   localparam int HW  = FRAC_BITS + 8;
   localparam int BW  = 2 * FRAC_BITS + 8;

   logic [WW-1:0]   wx0, wx1, wy0, wy1;
   logic [HW:0]     p_tl, p_tr, p_bl, p_br;
   logic [HW+1:0]   top_full, bot_full;
   logic [HW-1:0]   top_ff, top_in, bot_ff, bot_in;
   logic [FRAC_BITS-1:0] fy_ff;
   logic [BW:0]     p_top, p_bot;
   logic [BW+1:0]   vert_full;
   logic [BW-1:0]   bil_ff, bil_in;

   // horizontal pass, straight from the input ports
   always_comb begin
      wx1      = {1'b0, frac_x};
      wx0      = WW'(ONE) - wx1;
      p_tl     = texel_tl * wx0;
      p_tr     = texel_tr * wx1;
      p_bl     = texel_bl * wx0;
      p_br     = texel_br * wx1;
      top_full = (HW+2)'(p_tl) + (HW+2)'(p_tr);
      bot_full = (HW+2)'(p_bl) + (HW+2)'(p_br);
      top_in   = top_full[HW-1:0];
      bot_in   = bot_full[HW-1:0];
   end

   // vertical pass
   always_comb begin
      wy1       = {1'b0, fy_ff};
      wy0       = WW'(ONE) - wy1;
      p_top     = top_ff * wy0;
      p_bot     = bot_ff * wy1;
      vert_full = (BW+2)'(p_top) + (BW+2)'(p_bot);
      bil_in    = vert_full[BW-1:0];
   end

   always_ff @(posedge clock) begin
      if (ctl.en[0]) begin
         top_ff <= top_in;
         bot_ff <= bot_in;
         fy_ff  <= frac_y;
      end
      if (ctl.en[1]) begin
         bil_ff <= bil_in;
      end
   end

   assign bilerp_value = bil_ff;

endmodule

`default_nettype wire

>>> design/btmb_blend.sv
// modulation, over composite, rounding and saturation of all four channels
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module btmb_blend import btmb_pkg::*; #(
   parameter int FRAC_BITS = 8
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic [CHANNELS-1:0][2*FRAC_BITS+7:0]  bilerp_value,
   input  wire logic [CHANNELS-1:0][7:0]              dest_chan,
   input  wire blend_factor_type                      factors,
   input  wire pipe_ctl_type                          ctl,
   output logic [CHANNELS-1:0][7:0]                   out_chan
);

   localparam int BW = 2 * FRAC_BITS + 8;
   localparam int AW = BW + 8;
   localparam int PW = BW + 16;
   localparam int SW = PW + 1;
   localparam int QW = QIN_W + TRUNC_W;
   localparam longint DEN_L = longint'(BLEND_DIV) << (2 * FRAC_BITS);
   localparam logic [AW-1:0] DEN  = AW'(DEN_L);
   localparam logic [SW-1:0] HALF = SW'(DEN_L >> 1);

   // stage 3
   logic [CHANNELS-1:0][PW-1:0] prod_ff, prod_in;
   logic [AW-1:0]               am_ff, am_in;
   logic [CHANNELS-1:0][7:0]    dst_ff;
   // stage 4
   logic [AW-1:0]               keep;
   logic [CHANNELS-1:0][PW-1:0] dk_ff, dk_in, prod4_ff;
   // stage 5
   logic [CHANNELS-1:0][SW-1:0]      sum;
   logic [CHANNELS-1:0][TRUNC_W-1:0] trunc;
   logic [CHANNELS-1:0]              sat_ff, sat_in;
   logic [CHANNELS-1:0][QIN_W-1:0]   tq_ff, tq_in;
   // stage 6
   logic [CHANNELS-1:0][QW-1:0]      q_full;
   logic [CHANNELS-1:0][7:0]         q, out_ff, out_in;
   logic [CHANNELS-1:0][QIN_W-1:0]   q_times_div;
   logic [CHANNELS-1:0]              recip_ok;

   always_comb begin
      for (int c = 0; c < CHANNELS; c++) begin
         prod_in[c] = bilerp_value[c] * factors.factor[c];
      end
      am_in = bilerp_value[CH_ALPHA] * factors.mod_alpha;
   end

   // share of the destination left after the texel alpha
   always_comb begin
      keep = DEN - am_ff;
      for (int c = 0; c < CHANNELS; c++) begin
         dk_in[c] = dst_ff[c] * keep;
      end
   end

   // add half the denominator, drop the power of two part
   always_comb begin
      for (int c = 0; c < CHANNELS; c++) begin
         sum[c]    = SW'(prod4_ff[c]) + SW'(dk_ff[c]) + HALF;
         trunc[c]  = sum[c][2*FRAC_BITS +: TRUNC_W];
         sat_in[c] = trunc[c] >= TRUNC_W'(SAT_BOUND);
         tq_in[c]  = trunc[c][QIN_W-1:0];
      end
   end

   // divide by 255*255 through the reciprocal
   always_comb begin
      for (int c = 0; c < CHANNELS; c++) begin
         q_full[c]      = tq_ff[c] * RECIP_MUL;
         q[c]           = q_full[c][RECIP_SHIFT +: 8];
         out_in[c]      = sat_ff[c] ? 8'hFF : q[c];
         q_times_div[c] = q[c] * 16'(BLEND_DIV);
         recip_ok[c]    = sat_ff[c] ||
                          ((q_times_div[c] <= tq_ff[c]) &&
                           ((tq_ff[c] - q_times_div[c]) < QIN_W'(BLEND_DIV)));
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.en[2]) begin
         prod_ff <= prod_in;
         am_ff   <= am_in;
         dst_ff  <= dest_chan;
      end
      if (ctl.en[3]) begin
         dk_ff    <= dk_in;
         prod4_ff <= prod_ff;
      end
      if (ctl.en[4]) begin
         sat_ff <= sat_in;
         tq_ff  <= tq_in;
      end
      if (ctl.en[5]) begin
         out_ff <= out_in;
      end
   end

   assign out_chan = out_ff;

   `BTMB_ASSERT(a_alpha_within_den, ctl.valid[2] |-> (am_ff <= DEN), "modulated alpha above one")
   `BTMB_ASSERT(a_recip_exact, ctl.valid[4] |-> (&recip_ok), "reciprocal quotient off by one")

endmodule

`default_nettype wire
